// ----- rtl/usart_rx_pkg.sv -----
// Shared constants and types for the USART register block with receive FIFO.
`default_nettype none

package usart_rx_pkg;

	// Receive FIFO geometry
	localparam int FIFO_DEPTH = 16;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

	// Transaction kinds
	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_RX    = 2'd2;

	// Access sizes in bytes
	localparam logic [2:0] SIZE_BYTE = 3'd1;
	localparam logic [2:0] SIZE_HALF = 3'd2;
	localparam logic [2:0] SIZE_WORD = 3'd4;

	// Register offsets
	localparam logic [7:0] OFF_SR   = 8'h00;
	localparam logic [7:0] OFF_DR   = 8'h04;
	localparam logic [7:0] OFF_BRR  = 8'h08;
	localparam logic [7:0] OFF_CR1  = 8'h0C;
	localparam logic [7:0] OFF_CR2  = 8'h10;
	localparam logic [7:0] OFF_CR3  = 8'h14;
	localparam logic [7:0] OFF_GTPR = 8'h18;
	localparam logic [7:0] OFF_LAST = OFF_GTPR;

	// Status and control bit positions
	localparam int SR_RXNE = 5;
	localparam int SR_TC   = 6;
	localparam int SR_TXE  = 7;
	localparam int CR1_RE  = 2;
	localparam int CR1_TE  = 3;
	localparam int CR1_UE  = 13;

	localparam logic [7:0] SR_RESET = 8'hC0;
	localparam logic [8:0] DR_MASK  = 9'h1FF;

	// Sequencer states
	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} seq_state_t;

endpackage : usart_rx_pkg

`default_nettype wire

// ----- rtl/usart_register_block_rx_fifo.sv -----
// USART register block: bus register file plus receive FIFO held in a synchronous RAM.
// Usage:
//  Input channel (in_valid/in_stall) carries one transaction: a bus read, a bus
//  write or a byte received from the serial line. Output channel
//  (out_valid/out_stall) returns exactly one result per input transaction, in
//  order: error, read_data, tx_valid/tx_byte for a transmitting data write, and
//  rx_accepted for a line byte that entered the FIFO.
//  Timing: the FIFO head is read from the RAM at the accept edge; the
//  register/FIFO update and the result register load happen at the next edge.
//  Input holds off while a transaction executes: the RAM read of the FIFO
//  head precedes each read-modify-write of the FIFO pointers.
//  Reset (arst_n low): status = TXE|TC, all other registers zero, FIFO empty,
//  output empty. The FIFO RAM is not cleared; only written entries are read.
//  Receiver stall: the finished result waits in the output register; one
//  further transaction is accepted only once that result is taken, so
//  in_stall rises while out_stall holds a result back.
`default_nettype none

module usart_register_block_rx_fifo
	import usart_rx_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  kind,
	input  wire logic [7:0]  reg_offset,
	input  wire logic [2:0]  access_size,
	input  wire logic [31:0] write_data,
	input  wire logic [7:0]  line_byte,
	input  wire logic        clock_on,
	// output channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             error,
	output logic [31:0]      read_data,
	output logic             tx_valid,
	output logic [7:0]       tx_byte,
	output logic             rx_accepted
);

	// Sequencer
	seq_state_t state_q, state_d;
	logic       in_accept;
	logic       exec_en;

	// Captured transaction
	logic [1:0]  kind_s1;
	logic [7:0]  reg_offset_s1;
	logic [2:0]  access_size_s1;
	logic [31:0] write_data_s1;
	logic [7:0]  line_byte_s1;
	logic        clock_on_s1;

	// Register file
	logic [7:0]  status_q, status_d;
	logic [8:0]  data_q, data_d;
	logic [15:0] baud_q, baud_d;
	logic [31:0] cr1_q, cr1_d;
	logic [31:0] cr2_q, cr2_d;
	logic [31:0] cr3_q, cr3_d;
	logic [31:0] gtpr_q, gtpr_d;

	// FIFO pointers and RAM
	logic [PTR_W-1:0]  head_q, head_d;
	logic [FILL_W-1:0] fill_q, fill_d;
	logic [FILL_W:0]   tail_sum;
	logic [PTR_W-1:0]  tail_idx;
	logic [7:0]        rx_mem [FIFO_DEPTH];
	logic [7:0]        rd_data_q;
	logic              mem_we;

	// Result
	logic        out_valid_q;
	logic        error_q, error_d;
	logic [31:0] read_data_q, read_data_d;
	logic        tx_valid_q, tx_valid_d;
	logic [7:0]  tx_byte_q, tx_byte_d;
	logic        rx_acc_q, rx_acc_d;

	logic        size_ok;
	logic        off_ok;
	logic [31:0] rdata;

	assign in_accept = in_valid && !in_stall;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_accept) state_d = ST_EXEC;
			end
			ST_EXEC: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: hold off while executing or while a result is stuck
	always_comb begin
		exec_en  = 1'b0;
		in_stall = 1'b0;
		case (state_q)
			ST_IDLE: in_stall = out_valid_q && out_stall;
			ST_EXEC: begin
				exec_en  = 1'b1;
				in_stall = 1'b1;
			end
			default: in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Capture the transaction
	always_ff @(posedge clk) begin
		if (in_accept) begin
			kind_s1        <= kind;
			reg_offset_s1  <= reg_offset;
			access_size_s1 <= access_size;
			write_data_s1  <= write_data;
			line_byte_s1   <= line_byte;
			clock_on_s1    <= clock_on;
		end
	end

	// FIFO RAM: head read at accept, tail write at execute
	always_ff @(posedge clk) begin
		if (mem_we) rx_mem[tail_idx] <= line_byte_s1;
		if (in_accept) rd_data_q <= rx_mem[head_q];
	end

	// Tail = (head + fill) mod depth; both below depth when a write happens
	assign tail_sum = (FILL_W+1)'(head_q) + (FILL_W+1)'(fill_q);
	assign tail_idx = (tail_sum >= (FILL_W+1)'(FIFO_DEPTH))
		? PTR_W'(tail_sum - (FILL_W+1)'(FIFO_DEPTH)) : PTR_W'(tail_sum);

	assign size_ok = access_size_s1 inside {SIZE_BYTE, SIZE_HALF, SIZE_WORD};
	assign off_ok  = (reg_offset_s1 <= OFF_LAST) && (reg_offset_s1[1:0] == 2'b00);

	// Execute: register/FIFO read-modify-write and result
	always_comb begin
		status_d    = status_q;
		data_d      = data_q;
		baud_d      = baud_q;
		cr1_d       = cr1_q;
		cr2_d       = cr2_q;
		cr3_d       = cr3_q;
		gtpr_d      = gtpr_q;
		head_d      = head_q;
		fill_d      = fill_q;
		mem_we      = 1'b0;
		rdata       = '0;
		error_d     = 1'b0;
		read_data_d = '0;
		tx_valid_d  = 1'b0;
		tx_byte_d   = '0;
		rx_acc_d    = 1'b0;
		if (exec_en) begin
			if (kind_s1 == KIND_READ || kind_s1 == KIND_WRITE) begin
				if (!size_ok) begin
					error_d = 1'b1;
				end else if (!clock_on_s1) begin
					// gated clock: read gives zero, write dropped
					error_d = 1'b0;
				end else if (!off_ok) begin
					error_d = 1'b1;
				end else if (kind_s1 == KIND_READ) begin
					case (reg_offset_s1)
						OFF_SR: rdata = {24'd0, status_q};
						OFF_DR: begin
							if (fill_q != '0) begin
								// pop the head byte
								rdata  = {24'd0, rd_data_q};
								head_d = (head_q == PTR_W'(FIFO_DEPTH - 1))
									? '0 : head_q + PTR_W'(1);
								fill_d = fill_q - FILL_W'(1);
								if (fill_q == FILL_W'(1)) status_d[SR_RXNE] = 1'b0;
							end else begin
								rdata = {23'd0, data_q};
							end
						end
						OFF_BRR: rdata = {16'd0, baud_q};
						OFF_CR1: rdata = cr1_q;
						OFF_CR2: rdata = cr2_q;
						OFF_CR3: rdata = cr3_q;
						default: rdata = gtpr_q;
					endcase
					case (access_size_s1)
						SIZE_BYTE: read_data_d = rdata & 32'h0000_00FF;
						SIZE_HALF: read_data_d = rdata & 32'h0000_FFFF;
						default:   read_data_d = rdata;
					endcase
				end else begin
					case (reg_offset_s1)
						OFF_SR: begin
							// clear-by-zero, TXE forced back on
							status_d         = status_q & write_data_s1[7:0];
							status_d[SR_TXE] = 1'b1;
						end
						OFF_DR: begin
							data_d = write_data_s1[8:0] & DR_MASK;
							if (cr1_q[CR1_UE] && cr1_q[CR1_TE]) begin
								tx_valid_d       = 1'b1;
								tx_byte_d        = write_data_s1[7:0];
								status_d[SR_TXE] = 1'b1;
								status_d[SR_TC]  = 1'b1;
							end
						end
						OFF_BRR: baud_d = write_data_s1[15:0];
						OFF_CR1: cr1_d = write_data_s1;
						OFF_CR2: cr2_d = write_data_s1;
						OFF_CR3: cr3_d = write_data_s1;
						default: gtpr_d = write_data_s1;
					endcase
				end
			end else if (kind_s1 == KIND_RX) begin
				// receiver enabled: push if room; FIFO is then non-empty
				if (cr1_q[CR1_UE] && cr1_q[CR1_RE]) begin
					if (fill_q < FILL_W'(FIFO_DEPTH)) begin
						mem_we   = 1'b1;
						fill_d   = fill_q + FILL_W'(1);
						rx_acc_d = 1'b1;
					end
					status_d[SR_RXNE] = 1'b1;
				end
			end
		end
	end

	// Register file and pointer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= SR_RESET;
			data_q   <= '0;
			baud_q   <= '0;
			cr1_q    <= '0;
			cr2_q    <= '0;
			cr3_q    <= '0;
			gtpr_q   <= '0;
			head_q   <= '0;
			fill_q   <= '0;
		end else begin
			status_q <= status_d;
			data_q   <= data_d;
			baud_q   <= baud_d;
			cr1_q    <= cr1_d;
			cr2_q    <= cr2_d;
			cr3_q    <= cr3_d;
			gtpr_q   <= gtpr_d;
			head_q   <= head_d;
			fill_q   <= fill_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_en) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_en) begin
			error_q     <= error_d;
			read_data_q <= read_data_d;
			tx_valid_q  <= tx_valid_d;
			tx_byte_q   <= tx_byte_d;
			rx_acc_q    <= rx_acc_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign error       = error_q;
	assign read_data   = read_data_q;
	assign tx_valid    = tx_valid_q;
	assign tx_byte     = tx_byte_q;
	assign rx_accepted = rx_acc_q;

`ifndef SYNTHESIS
	// FIFO occupancy never exceeds its depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(FIFO_DEPTH))
		else $error("rx fifo fill above depth");

	// Occupancy moves by at most one per transaction
	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> (fill_q == $past(fill_q) || fill_q == $past(fill_q) + FILL_W'(1)
			|| fill_q == $past(fill_q) - FILL_W'(1)))
		else $error("rx fifo fill jumped");

	// Every accepted transaction yields a result once it has executed
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> ##2 out_valid)
		else $error("result missing after accept");

	// A transmit result never also flags an error or a receive
	a_result_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && tx_valid) |-> (!error && !rx_accepted))
		else $error("conflicting result flags");
`endif

endmodule : usart_register_block_rx_fifo

`default_nettype wire

// ----- sim/usart_register_block_rx_fifo_tb.sv -----
// Self-checking testbench for the USART register block with receive FIFO.
`timescale 1ns / 100ps

module usart_register_block_rx_fifo_tb
	import usart_rx_pkg::*;
();

	// Codes not covered by the package
	localparam logic [1:0] KIND_UNUSED   = 2'd3;
	localparam logic [2:0] SIZE_NONE     = 3'd0;
	localparam logic [2:0] SIZE_ODD      = 3'd3;
	localparam logic [2:0] SIZE_TOP      = 3'd7;
	localparam logic [7:0] OFF_PAST_END  = 8'h1C;
	localparam logic [7:0] OFF_UNALIGNED = 8'h02;
	localparam logic [7:0] OFF_TOP       = 8'hFF;

	// One expected result
	typedef struct packed {
		logic        err;
		logic [31:0] rdata;
		logic        txv;
		logic [7:0]  txb;
		logic        rxa;
	} usart_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  kind = '0;
	logic [7:0]  reg_offset = '0;
	logic [2:0]  access_size = '0;
	logic [31:0] write_data = '0;
	logic [7:0]  line_byte = '0;
	logic        clock_on = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        error;
	logic [31:0] read_data;
	logic        tx_valid;
	logic [7:0]  tx_byte;
	logic        rx_accepted;

	// Idle rates in percent
	int src_idle_pct = 0;
	int stall_pct = 0;
	int mismatch_count = 0;

	usart_result_t pending_results[$];

	// Shadow copy of the register file and FIFO
	logic [7:0]        sr_q;
	logic [8:0]        dr_q;
	logic [15:0]       brr_q;
	logic [31:0]       cr1_q, cr2_q, cr3_q, gtpr_q;
	logic [7:0]        rx_mem [FIFO_DEPTH];
	logic [PTR_W-1:0]  rx_head;
	logic [FILL_W-1:0] rx_level;

	usart_register_block_rx_fifo u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.reg_offset (reg_offset),
		.access_size(access_size),
		.write_data (write_data),
		.line_byte  (line_byte),
		.clock_on   (clock_on),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.error      (error),
		.read_data  (read_data),
		.tx_valid   (tx_valid),
		.tx_byte    (tx_byte),
		.rx_accepted(rx_accepted)
	);

	// Clock
	initial begin
		forever #1 clk = ~clk;
	end

	// Hard limit on run time
	initial begin
		#2000000;
		$display("** usart_register_block_rx_fifo: FAILED **");
		$finish;
	end

	// Receiver backpressure
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Work out the result of one accepted transaction and queue it
	task automatic predict_result(input logic [1:0] k, input logic [7:0] off,
			input logic [2:0] sz, input logic [31:0] wd, input logic [7:0] lb,
			input logic con);
		usart_result_t r;
		logic size_good;
		logic off_good;
		logic [PTR_W-1:0] tail;
		r = '0;
		size_good = (sz == SIZE_BYTE) || (sz == SIZE_HALF) || (sz == SIZE_WORD);
		off_good = (off <= OFF_LAST) && (off[1:0] == 2'b00);
		if (k == KIND_READ || k == KIND_WRITE) begin
			// size check wins over the clock gate, the gate over the offset check
			if (!size_good) begin
				r.err = 1'b1;
			end else if (!con) begin
				// gated: nothing happens
			end else if (!off_good) begin
				r.err = 1'b1;
			end else if (k == KIND_READ) begin
				case (off)
					OFF_SR: r.rdata = {24'd0, sr_q};
					OFF_DR: begin
						if (rx_level != 0) begin
							r.rdata = {24'd0, rx_mem[rx_head]};
							rx_head = rx_head + 1'b1;
							rx_level = rx_level - 1'b1;
							if (rx_level == 0)
								sr_q[SR_RXNE] = 1'b0;
						end else begin
							r.rdata = {23'd0, dr_q};
						end
					end
					OFF_BRR: r.rdata = {16'd0, brr_q};
					OFF_CR1: r.rdata = cr1_q;
					OFF_CR2: r.rdata = cr2_q;
					OFF_CR3: r.rdata = cr3_q;
					default: r.rdata = gtpr_q;
				endcase
				if (sz == SIZE_BYTE)
					r.rdata = r.rdata & 32'h0000_00FF;
				else if (sz == SIZE_HALF)
					r.rdata = r.rdata & 32'h0000_FFFF;
			end else begin
				case (off)
					OFF_SR: begin
						sr_q = sr_q & wd[7:0];
						sr_q[SR_TXE] = 1'b1;
					end
					OFF_DR: begin
						dr_q = wd[8:0];
						if (cr1_q[CR1_UE] && cr1_q[CR1_TE]) begin
							r.txv = 1'b1;
							r.txb = wd[7:0];
							sr_q[SR_TXE] = 1'b1;
							sr_q[SR_TC] = 1'b1;
						end
					end
					OFF_BRR: brr_q = wd[15:0];
					OFF_CR1: cr1_q = wd;
					OFF_CR2: cr2_q = wd;
					OFF_CR3: cr3_q = wd;
					default: gtpr_q = wd;
				endcase
			end
		end else if (k == KIND_RX) begin
			// reception ignores the clock gate
			if (cr1_q[CR1_UE] && cr1_q[CR1_RE]) begin
				if (rx_level < FIFO_DEPTH) begin
					tail = rx_head + rx_level[PTR_W-1:0];
					rx_mem[tail] = lb;
					rx_level = rx_level + 1'b1;
					r.rxa = 1'b1;
				end
				if (rx_level != 0)
					sr_q[SR_RXNE] = 1'b1;
			end
		end
		pending_results.push_back(r);
	endtask

	// Drive one transaction, wait for acceptance, then predict it
	task automatic send_txn(input logic [1:0] k, input logic [7:0] off,
			input logic [2:0] sz, input logic [31:0] wd, input logic [7:0] lb,
			input logic con);
		while ($urandom_range(99) < src_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid    <= 1'b1;
		kind        <= k;
		reg_offset  <= off;
		access_size <= sz;
		write_data  <= wd;
		line_byte   <= lb;
		clock_on    <= con;
		do
			@(posedge clk);
		while (in_stall);
		predict_result(k, off, sz, wd, lb, con);
	endtask

	task automatic note_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h",
				$realtime, what, want, got);
	endtask

	// Compare each result with the oldest expectation
	always @(posedge clk) begin : check_results
		usart_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				note_mismatch("unexpected result", 32'd0, read_data);
			end else begin
				want = pending_results.pop_front();
				if (error !== want.err)
					note_mismatch("error", want.err, error);
				if (read_data !== want.rdata)
					note_mismatch("read_data", want.rdata, read_data);
				if (tx_valid !== want.txv)
					note_mismatch("tx_valid", want.txv, tx_valid);
				if (tx_byte !== want.txb)
					note_mismatch("tx_byte", want.txb, tx_byte);
				if (rx_accepted !== want.rxa)
					note_mismatch("rx_accepted", want.rxa, rx_accepted);
			end
		end
	end

	function automatic logic [2:0] pick_size();
		case ($urandom_range(2))
			0: return SIZE_BYTE;
			1: return SIZE_HALF;
			default: return SIZE_WORD;
		endcase
	endfunction

	function automatic logic [7:0] pick_offset();
		case ($urandom_range(6))
			0: return OFF_SR;
			1: return OFF_DR;
			2: return OFF_BRR;
			3: return OFF_CR1;
			4: return OFF_CR2;
			5: return OFF_CR3;
			default: return OFF_GTPR;
		endcase
	endfunction

	task automatic test_reset_values();
		send_txn(KIND_READ, OFF_SR, SIZE_WORD, '0, '0, 1'b1);
		send_txn(KIND_READ, OFF_DR, SIZE_WORD, '0, '0, 1'b1);
	endtask

	task automatic test_access_errors();
		send_txn(KIND_READ, OFF_SR, SIZE_ODD, '0, '0, 1'b1);
		send_txn(KIND_WRITE, OFF_CR1, SIZE_TOP, 32'hFFFF_FFFF, '0, 1'b1);
		send_txn(KIND_READ, OFF_SR, SIZE_NONE, '0, '0, 1'b0);
		send_txn(KIND_READ, OFF_PAST_END, SIZE_WORD, '0, '0, 1'b1);
		send_txn(KIND_READ, OFF_UNALIGNED, SIZE_HALF, '0, '0, 1'b1);
	endtask

	task automatic test_clock_gate();
		send_txn(KIND_READ, OFF_TOP, SIZE_WORD, '0, '0, 1'b0);
		send_txn(KIND_WRITE, OFF_CR1, SIZE_WORD, 32'hFFFF_FFFF, '0, 1'b0);
	endtask

	task automatic test_register_widths();
		send_txn(KIND_WRITE, OFF_BRR, SIZE_WORD, 32'hFFFF_FFFF, '0, 1'b1);
		send_txn(KIND_READ, OFF_BRR, SIZE_BYTE, '0, '0, 1'b1);
		send_txn(KIND_WRITE, OFF_GTPR, SIZE_WORD, 32'hFFFF_FFFF, '0, 1'b1);
		send_txn(KIND_READ, OFF_GTPR, SIZE_HALF, '0, '0, 1'b1);
	endtask

	task automatic test_transmit();
		logic [31:0] enables;
		enables = '0;
		enables[CR1_UE] = 1'b1;
		enables[CR1_TE] = 1'b1;
		enables[CR1_RE] = 1'b1;
		send_txn(KIND_WRITE, OFF_CR1, SIZE_WORD, enables, '0, 1'b1);
		send_txn(KIND_WRITE, OFF_DR, SIZE_WORD, 32'hFFFF_FFFF, '0, 1'b1);
		// status write clears everything but TXE
		send_txn(KIND_WRITE, OFF_SR, SIZE_WORD, 32'h0, '0, 1'b1);
		send_txn(KIND_READ, OFF_SR, SIZE_BYTE, '0, '0, 1'b1);
	endtask

	task automatic test_receive_fifo();
		// two bytes in, status shows RXNE, pop both, then fall back to data
		send_txn(KIND_RX, '0, '0, '0, 8'hFF, 1'b0);
		send_txn(KIND_RX, '0, '0, '0, 8'h00, 1'b1);
		send_txn(KIND_READ, OFF_SR, SIZE_WORD, '0, '0, 1'b1);
		send_txn(KIND_READ, OFF_DR, SIZE_WORD, '0, '0, 1'b1);
		send_txn(KIND_READ, OFF_DR, SIZE_BYTE, '0, '0, 1'b1);
		send_txn(KIND_READ, OFF_DR, SIZE_WORD, '0, '0, 1'b1);
	endtask

	task automatic test_receiver_off();
		send_txn(KIND_WRITE, OFF_CR1, SIZE_WORD, 32'h0, '0, 1'b1);
		send_txn(KIND_RX, '0, '0, '0, 8'hA5, 1'b1);
	endtask

	task automatic test_unused_kind();
		send_txn(KIND_UNUSED, OFF_CR1, SIZE_WORD, 32'hFFFF_FFFF, 8'hFF, 1'b1);
	endtask

	// Bursts of received bytes and data reads, register traffic, data writes and noise
	task automatic test_random(input int n_items, input int src_pct, input int dst_pct);
		int sent;
		int mode;
		int burst;
		logic [1:0]  k;
		logic [7:0]  off;
		logic [31:0] wd;
		src_idle_pct = src_pct;
		stall_pct = dst_pct;
		sent = 0;
		while (sent < n_items) begin
			mode = $urandom_range(99);
			burst = $urandom_range(1, 20);
			if (mode < 30) begin
				repeat (burst) begin
					send_txn(KIND_RX, '0, '0, '0, 8'($urandom), $urandom_range(9) != 0);
					sent++;
				end
			end else if (mode < 55) begin
				repeat (burst) begin
					send_txn(KIND_READ, OFF_DR, pick_size(), '0, '0,
						$urandom_range(9) != 0);
					sent++;
				end
			end else if (mode < 75) begin
				k = $urandom_range(1) ? KIND_WRITE : KIND_READ;
				off = pick_offset();
				wd = $urandom;
				// mostly keep the transmitter and receiver enabled
				if (off == OFF_CR1 && $urandom_range(4) != 0) begin
					wd[CR1_UE] = 1'b1;
					wd[CR1_TE] = 1'b1;
					wd[CR1_RE] = 1'b1;
				end
				send_txn(k, off, pick_size(), k == KIND_WRITE ? wd : 32'h0, '0,
					$urandom_range(9) != 0);
				sent++;
			end else if (mode < 85) begin
				send_txn(KIND_WRITE, OFF_DR, pick_size(), $urandom, '0, 1'b1);
				sent++;
			end else begin
				send_txn(2'($urandom_range(3)), 8'($urandom_range(255)),
					3'($urandom_range(7)), $urandom, 8'($urandom_range(255)),
					1'($urandom_range(1)));
				sent++;
			end
		end
	endtask

	// Sequence of tests
	initial begin
		sr_q = SR_RESET;
		dr_q = '0;
		brr_q = '0;
		cr1_q = '0;
		cr2_q = '0;
		cr3_q = '0;
		gtpr_q = '0;
		rx_head = '0;
		rx_level = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_values();
		test_access_errors();
		test_clock_gate();
		test_register_widths();
		test_transmit();
		test_receive_fifo();
		test_receiver_off();
		test_unused_kind();

		test_random(270, 20, 84);
		test_random(270, 84, 20);
		test_random(260, 0, 0);

		// drain outstanding results
		@(negedge clk);
		in_valid <= 1'b0;
		stall_pct = 0;
		for (int i = 0; i < 20000 && pending_results.size() != 0; i++)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (pending_results.size() != 0)
			$display("%0d expected results never arrived", pending_results.size());
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("** usart_register_block_rx_fifo: PASSED **");
		end else begin
			$display("** usart_register_block_rx_fifo: FAILED **");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/usart_rx_pkg.sv
rtl/usart_register_block_rx_fifo.sv
sim/usart_register_block_rx_fifo_tb.sv
